### src/plex_pkg.sv
// Shared types, token codes and the keyword table of the pseudocode lexer.
package plex_pkg;

  // Token kinds.
  localparam logic [5:0] K_LPAREN   = 6'd0;
  localparam logic [5:0] K_RPAREN   = 6'd1;
  localparam logic [5:0] K_LBRACE   = 6'd2;
  localparam logic [5:0] K_RBRACE   = 6'd3;
  localparam logic [5:0] K_LBRACKET = 6'd4;
  localparam logic [5:0] K_RBRACKET = 6'd5;
  localparam logic [5:0] K_COMMA    = 6'd6;
  localparam logic [5:0] K_EQ       = 6'd7;
  localparam logic [5:0] K_NE       = 6'd8;
  localparam logic [5:0] K_PLUS     = 6'd9;
  localparam logic [5:0] K_MINUS    = 6'd10;
  localparam logic [5:0] K_STAR     = 6'd11;
  localparam logic [5:0] K_SLASH    = 6'd12;
  localparam logic [5:0] K_LT       = 6'd13;
  localparam logic [5:0] K_LE       = 6'd14;
  localparam logic [5:0] K_ARROW    = 6'd15;
  localparam logic [5:0] K_GT       = 6'd16;
  localparam logic [5:0] K_GE       = 6'd17;
  localparam logic [5:0] K_IDENT    = 6'd18;
  localparam logic [5:0] K_STRING   = 6'd19;
  localparam logic [5:0] K_NUMBER   = 6'd20;
  localparam logic [5:0] K_KW_BASE  = 6'd21;
  localparam logic [5:0] K_ERROR    = 6'd37;
  localparam logic [5:0] K_EOF      = 6'd38;

  // Error codes.
  localparam logic [1:0] E_NONE   = 2'd0;
  localparam logic [1:0] E_UNTERM = 2'd1;
  localparam logic [1:0] E_UNEXP  = 2'd2;

  localparam logic [15:0] LEN_MAX = 16'hFFFF;

  // Keyword table; text is right-justified, first character in the high byte.
  localparam int KW_CHARS = 9;
  localparam int KW_COUNT = 16;
  localparam int KW_IDX_BITS = $clog2(KW_CHARS);

  localparam logic [8*KW_CHARS-1:0] KW_TEXT [KW_COUNT] = '{
    72'("AND"), 72'("ELSE"), 72'("EACH"), 72'("FOR"), 72'("FALSE"),
    72'("IF"), 72'("IN"), 72'("MOD"), 72'("NOT"), 72'("OR"),
    72'("PROCEDURE"), 72'("RETURN"), 72'("REPEAT"), 72'("TIMES"),
    72'("TRUE"), 72'("UNTIL")
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd3, 4'd4, 4'd4, 4'd3, 4'd5, 4'd2, 4'd2, 4'd3, 4'd3, 4'd2,
    4'd9, 4'd6, 4'd6, 4'd5, 4'd4, 4'd5
  };

  typedef struct packed {
    logic [5:0]  kind;
    logic [1:0]  err_code;
    logic [15:0] start_pos;
    logic [15:0] tok_len;
    logic [15:0] line_no;
    logic        last;
  } plex_res_t;

  // Results of one step, packed toward res0.
  typedef struct packed {
    logic [1:0] cnt;
    plex_res_t  res0;
    plex_res_t  res1;
  } plex_push_t;

  // Keyword lookup on the first characters of an identifier. Entries at or
  // beyond len_i do not affect the result.
  function automatic logic [5:0] kw_kind(input logic [7:0] wbuf_i [KW_CHARS],
                                         input logic [15:0] len_i);
    logic [5:0] k;
    logic       hit;
    k = K_IDENT;
    for (int i = 0; i < KW_COUNT; i++) begin
      hit = (len_i == {12'd0, KW_LEN[i]});
      for (int j = 0; j < KW_CHARS; j++) begin
        if (j < int'(KW_LEN[i])) begin
          if (wbuf_i[j] != KW_TEXT[i][(int'(KW_LEN[i]) - 1 - j) * 8 +: 8]) begin
            hit = 1'b0;
          end
        end
      end
      if (hit) begin
        k = 6'(int'(K_KW_BASE) + i);
      end
    end
    return k;
  endfunction

endpackage

### src/pseudocode_lexer_unit.sv
// Streaming pseudocode lexer: one source byte per transfer in, tokens out.
// The scanner takes one source byte per cycle unless the input is stalled. A byte
// sits in an input register, is scanned from there and its results enter a
// four-entry result queue, from whose head tokens reach the output. A byte that
// closes one token and opens another gives two results; the output port hands
// over one result per cycle while out_stall_i is low, so input is held off only
// while the queue holds more than two results. Byte 0 ends the source, yields
// the end-of-file token and puts the line count back to one.
module pseudocode_lexer_unit #(
  parameter int POS_BITS  = 16,
  parameter int LINE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  ch_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [5:0]  kind_o,
  output logic [1:0]  err_code_o,
  output logic [15:0] start_pos_o,
  output logic [15:0] tok_len_o,
  output logic [15:0] line_no_o,
  output logic        last_o
);
  import plex_pkg::*;

  logic       in_valid_q;
  logic [7:0] ch_q;
  logic       room2, fire;
  plex_push_t push;
  plex_res_t  head;

  assign fire       = in_valid_q && room2;
  assign in_stall_o = in_valid_q && !room2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      ch_q <= ch_i;
    end
  end

  plex_core #(
    .POS_BITS (POS_BITS),
    .LINE_BITS(LINE_BITS)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .fire_i(fire),
    .ch_i  (ch_q),
    .push_o(push)
  );

  plex_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_en_i  (fire),
    .push_i     (push),
    .room2_o    (room2),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .head_o     (head)
  );

  assign kind_o      = head.kind;
  assign err_code_o  = head.err_code;
  assign start_pos_o = head.start_pos;
  assign tok_len_o   = head.tok_len;
  assign line_no_o   = head.line_no;
  assign last_o      = head.last;

endmodule

### src/plex_core.sv
// Scanner state and the combinational step that turns one byte into results.
module plex_core #(
  parameter int POS_BITS  = 16,
  parameter int LINE_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic [7:0]          ch_i,
  output plex_pkg::plex_push_t push_o
);
  import plex_pkg::*;

  localparam logic [3:0] M_IDLE = 4'd0;
  localparam logic [3:0] M_INT  = 4'd1;
  localparam logic [3:0] M_FRAC = 4'd2;
  localparam logic [3:0] M_WORD = 4'd3;
  localparam logic [3:0] M_STR  = 4'd4;
  localparam logic [3:0] M_ESC  = 4'd5;
  localparam logic [3:0] M_BANG = 4'd6;
  localparam logic [3:0] M_LT   = 4'd7;
  localparam logic [3:0] M_GT   = 4'd8;

  logic [3:0]           mode_q, mode_d;
  logic [POS_BITS-1:0]  tstart_q, tstart_d;
  logic [POS_BITS-1:0]  cur_q, cur_d;
  logic [LINE_BITS-1:0] line_q, line_d;
  logic [15:0]          wlen_q, wlen_d;
  logic [7:0]           wbuf_q [KW_CHARS];

  logic                   wb_we;
  logic [KW_IDX_BITS-1:0] wb_idx;

  logic [15:0] cur16, tstart16, line16, wlen_grow;
  logic        a_v, b_v, rest, is_digit, is_alpha;
  plex_res_t   a_res, b_res;

  // Output fields are 16 bits wide and clamp at their maximum.
  if (POS_BITS > 16) begin : g_pos_wide
    assign cur16    = (|cur_q[POS_BITS-1:16]) ? LEN_MAX : cur_q[15:0];
    assign tstart16 = (|tstart_q[POS_BITS-1:16]) ? LEN_MAX : tstart_q[15:0];
  end else if (POS_BITS == 16) begin : g_pos_same
    assign cur16    = cur_q;
    assign tstart16 = tstart_q;
  end else begin : g_pos_narrow
    assign cur16    = {{(16-POS_BITS){1'b0}}, cur_q};
    assign tstart16 = {{(16-POS_BITS){1'b0}}, tstart_q};
  end

  if (LINE_BITS > 16) begin : g_line_wide
    assign line16 = (|line_q[LINE_BITS-1:16]) ? LEN_MAX : line_q[15:0];
  end else if (LINE_BITS == 16) begin : g_line_same
    assign line16 = line_q;
  end else begin : g_line_narrow
    assign line16 = {{(16-LINE_BITS){1'b0}}, line_q};
  end

  assign wlen_grow = (wlen_q != LEN_MAX) ? wlen_q + 16'd1 : wlen_q;
  assign is_digit  = ch_i inside {["0":"9"]};
  assign is_alpha  = (ch_i inside {["a":"z"], ["A":"Z"]}) || (ch_i == "_");

  function automatic plex_res_t mk(input logic [5:0] kind, input logic [1:0] err,
                                   input logic [15:0] start, input logic [15:0] len,
                                   input logic [15:0] line, input logic last);
    plex_res_t r;
    r.kind      = kind;
    r.err_code  = err;
    r.start_pos = start;
    r.tok_len   = len;
    r.line_no   = line;
    r.last      = last;
    return r;
  endfunction

  always_comb begin
    mode_d   = M_IDLE;
    tstart_d = tstart_q;
    wlen_d   = wlen_q;
    line_d   = line_q;
    cur_d    = (cur_q != '1) ? cur_q + 1'b1 : cur_q;
    wb_we    = 1'b0;
    wb_idx   = wlen_q[KW_IDX_BITS-1:0];
    rest     = 1'b1;
    a_v      = 1'b0;
    b_v      = 1'b0;
    a_res    = mk(K_NUMBER, E_NONE, tstart16, wlen_q, line16, 1'b0);
    b_res    = mk(K_ERROR, E_UNEXP, cur16, 16'd1, line16, 1'b0);

    // First finish or extend the pending token.
    case (mode_q)
      M_INT, M_FRAC: begin
        if (is_digit) begin
          wlen_d = wlen_grow;
          mode_d = mode_q;
          rest   = 1'b0;
        end else if (mode_q == M_INT && ch_i == ".") begin
          wlen_d = wlen_grow;
          mode_d = M_FRAC;
          rest   = 1'b0;
        end else begin
          a_v = 1'b1;
        end
      end
      M_WORD: begin
        if (is_alpha || is_digit) begin
          wb_we  = (wlen_q < 16'(KW_CHARS));
          wlen_d = wlen_grow;
          mode_d = M_WORD;
          rest   = 1'b0;
        end else begin
          a_v   = 1'b1;
          a_res = mk(kw_kind(wbuf_q, wlen_q), E_NONE, tstart16, wlen_q, line16, 1'b0);
        end
      end
      M_STR, M_ESC: begin
        if (ch_i == 8'h00 || ch_i == 8'h0A) begin
          a_v   = 1'b1;
          a_res = mk(K_ERROR, E_UNTERM, tstart16, wlen_q, line16, 1'b0);
        end else begin
          wlen_d = wlen_grow;
          rest   = 1'b0;
          if (mode_q == M_ESC) begin
            mode_d = M_STR;
          end else if (ch_i == "\\") begin
            mode_d = M_ESC;
          end else if (ch_i == "\"") begin
            a_v   = 1'b1;
            a_res = mk(K_STRING, E_NONE, tstart16, wlen_grow, line16, 1'b0);
          end else begin
            mode_d = M_STR;
          end
        end
      end
      M_BANG: begin
        a_v = 1'b1;
        if (ch_i == "=") begin
          a_res = mk(K_NE, E_NONE, tstart16, 16'd2, line16, 1'b0);
          rest  = 1'b0;
        end else begin
          a_res = mk(K_ERROR, E_UNEXP, tstart16, 16'd1, line16, 1'b0);
        end
      end
      M_LT: begin
        a_v = 1'b1;
        if (ch_i == "=") begin
          a_res = mk(K_LE, E_NONE, tstart16, 16'd2, line16, 1'b0);
          rest  = 1'b0;
        end else if (ch_i == "-") begin
          a_res = mk(K_ARROW, E_NONE, tstart16, 16'd2, line16, 1'b0);
          rest  = 1'b0;
        end else begin
          a_res = mk(K_LT, E_NONE, tstart16, 16'd1, line16, 1'b0);
        end
      end
      M_GT: begin
        a_v = 1'b1;
        if (ch_i == "=") begin
          a_res = mk(K_GE, E_NONE, tstart16, 16'd2, line16, 1'b0);
          rest  = 1'b0;
        end else begin
          a_res = mk(K_GT, E_NONE, tstart16, 16'd1, line16, 1'b0);
        end
      end
      default: begin
      end
    endcase

    // Then treat the byte as the start of something new, if it was not consumed.
    if (rest) begin
      case (ch_i)
        8'h00: begin
          b_v   = 1'b1;
          b_res = mk(K_EOF, E_NONE, cur16, 16'd0, line16, 1'b1);
        end
        8'h0A: begin
          if (line_q != '1) begin
            line_d = line_q + 1'b1;
          end
        end
        " ", 8'h09, 8'h0D: begin
        end
        "(": begin b_v = 1'b1; b_res = mk(K_LPAREN, E_NONE, cur16, 16'd1, line16, 1'b0); end
        ")": begin b_v = 1'b1; b_res = mk(K_RPAREN, E_NONE, cur16, 16'd1, line16, 1'b0); end
        "{": begin b_v = 1'b1; b_res = mk(K_LBRACE, E_NONE, cur16, 16'd1, line16, 1'b0); end
        "}": begin b_v = 1'b1; b_res = mk(K_RBRACE, E_NONE, cur16, 16'd1, line16, 1'b0); end
        "[": begin b_v = 1'b1; b_res = mk(K_LBRACKET, E_NONE, cur16, 16'd1, line16, 1'b0); end
        "]": begin b_v = 1'b1; b_res = mk(K_RBRACKET, E_NONE, cur16, 16'd1, line16, 1'b0); end
        ",": begin b_v = 1'b1; b_res = mk(K_COMMA, E_NONE, cur16, 16'd1, line16, 1'b0); end
        "=": begin b_v = 1'b1; b_res = mk(K_EQ, E_NONE, cur16, 16'd1, line16, 1'b0); end
        "+": begin b_v = 1'b1; b_res = mk(K_PLUS, E_NONE, cur16, 16'd1, line16, 1'b0); end
        "-": begin b_v = 1'b1; b_res = mk(K_MINUS, E_NONE, cur16, 16'd1, line16, 1'b0); end
        "*": begin b_v = 1'b1; b_res = mk(K_STAR, E_NONE, cur16, 16'd1, line16, 1'b0); end
        "/": begin b_v = 1'b1; b_res = mk(K_SLASH, E_NONE, cur16, 16'd1, line16, 1'b0); end
        "!", "<", ">", "\"": begin
          tstart_d = cur_q;
          wlen_d   = 16'd1;
          case (ch_i)
            "!":     mode_d = M_BANG;
            "<":     mode_d = M_LT;
            ">":     mode_d = M_GT;
            default: mode_d = M_STR;
          endcase
        end
        default: begin
          if (is_digit || is_alpha) begin
            tstart_d = cur_q;
            wlen_d   = 16'd1;
            mode_d   = is_digit ? M_INT : M_WORD;
            wb_we    = is_alpha;
            wb_idx   = '0;
          end else begin
            b_v = 1'b1;
          end
        end
      endcase
    end

    // End of source puts every counter back to its reset value.
    if (ch_i == 8'h00) begin
      mode_d   = M_IDLE;
      tstart_d = '0;
      cur_d    = '0;
      line_d   = LINE_BITS'(1);
      wlen_d   = '0;
    end
  end

  always_comb begin
    push_o.cnt  = {1'b0, a_v} + {1'b0, b_v};
    push_o.res0 = a_v ? a_res : b_res;
    push_o.res1 = b_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= M_IDLE;
      tstart_q <= '0;
      cur_q    <= '0;
      line_q   <= LINE_BITS'(1);
      wlen_q   <= '0;
    end else if (fire_i) begin
      mode_q   <= mode_d;
      tstart_q <= tstart_d;
      cur_q    <= cur_d;
      line_q   <= line_d;
      wlen_q   <= wlen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && wb_we) begin
      wbuf_q[wb_idx] <= ch_i;
    end
  end

endmodule

### src/plex_fifo.sv
// Four-entry result queue that takes up to two results per cycle while it has room for two.
module plex_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_en_i,
  input  plex_pkg::plex_push_t push_i,
  output logic                 room2_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output plex_pkg::plex_res_t  head_o
);
  import plex_pkg::*;

  plex_res_t  ent_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;
  logic [1:0] n_push;
  logic       pop;

  assign n_push      = push_en_i ? push_i.cnt : 2'd0;
  assign out_valid_o = (cnt_q != 3'd0);
  assign pop         = out_valid_o && !out_stall_i;
  assign room2_o     = (cnt_q <= 3'd2);
  assign head_o      = ent_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + n_push;
      rd_q  <= rd_q + {1'b0, pop};
      cnt_q <= cnt_q + {1'b0, n_push} - {2'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      ent_q[wr_q] <= push_i.res0;
    end
    if (n_push == 2'd2) begin
      ent_q[wr_q + 2'd1] <= push_i.res1;
    end
  end

endmodule

### src/plex_checker.sv
// Port-level checks for the pseudocode lexer, bound to the top level.
module plex_props (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [5:0]  kind_o,
  input logic [1:0]  err_code_o,
  input logic [15:0] start_pos_o,
  input logic [15:0] tok_len_o,
  input logic [15:0] line_no_o,
  input logic        last_o
);
  import plex_pkg::*;

  // A stalled result stays on the port with kind, start, length and line unchanged.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) &&
      $stable(start_pos_o) && $stable(tok_len_o) && $stable(line_no_o))
    else $error("stalled result changed");

  // The end marker is the end-of-file token and nothing else.
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (kind_o == K_EOF)) && (!last_o || tok_len_o == 16'd0))
    else $error("end marker mismatch");

  // Only error tokens carry an error code, and they always carry one.
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((kind_o == K_ERROR) == (err_code_o != E_NONE)))
    else $error("error code does not match kind");

  a_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> line_no_o != 16'd0)
    else $error("line number zero");

  // Two-character operators report a length of two.
  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == K_NE || kind_o == K_LE || kind_o == K_ARROW ||
      kind_o == K_GE) |-> tok_len_o == 16'd2)
    else $error("two-character operator with wrong length");

endmodule

bind pseudocode_lexer_unit plex_props u_plex_props (.*);

### bench/plex_checker.sv
// Token predictor and result checker for the pseudocode lexer.
module plex_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  ch_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [5:0]  kind_i,
  input  logic [1:0]  err_code_i,
  input  logic [15:0] start_pos_i,
  input  logic [15:0] tok_len_i,
  input  logic [15:0] line_no_i,
  input  logic        last_i,
  output int          fail_cnt_o,
  output int          pending_o,
  output int          checked_o
);
  import plex_pkg::*;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [15:0] SAT16 = 16'hFFFF;
  localparam int WORD_KEEP = 9;

  typedef enum logic [3:0] {
    SC_IDLE, SC_INT, SC_FRAC, SC_WORD, SC_STR, SC_ESC, SC_BANG, SC_LT, SC_GT
  } scan_e;

  // Keyword spellings in kind order, starting at K_KW_BASE.
  string kw_spell [16] = '{
    "AND", "ELSE", "EACH", "FOR", "FALSE", "IF", "IN", "MOD", "NOT", "OR",
    "PROCEDURE", "RETURN", "REPEAT", "TIMES", "TRUE", "UNTIL"
  };

  scan_e       scan_mode;
  logic [15:0] tok_start;
  logic [15:0] byte_pos;
  logic [15:0] line_cnt;
  logic [15:0] tok_len;
  logic [7:0]  word_chars [WORD_KEEP];
  plex_res_t   token_q [$];

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic [5:0] word_kind();
    logic [5:0] k;
    logic       hit;
    k = K_IDENT;
    for (int i = 0; i < 16; i++) begin
      hit = (kw_spell[i].len() == int'(tok_len));
      for (int j = 0; hit && j < kw_spell[i].len(); j++) begin
        if (word_chars[j] != kw_spell[i][j]) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        k = 6'(int'(K_KW_BASE) + i);
      end
    end
    return k;
  endfunction

  task automatic clear_scan();
    scan_mode = SC_IDLE;
    tok_start = '0;
    byte_pos  = '0;
    line_cnt  = 16'd1;
    tok_len   = '0;
    foreach (word_chars[i]) word_chars[i] = '0;
  endtask

  task automatic emit_token(input logic [5:0] kind, input logic [1:0] err,
                            input logic [15:0] start, input logic [15:0] len,
                            input logic last);
    plex_res_t t;
    t.kind      = kind;
    t.err_code  = err;
    t.start_pos = start;
    t.tok_len   = len;
    t.line_no   = line_cnt;
    t.last      = last;
    token_q.push_back(t);
  endtask

  task automatic open_token(input scan_e mode);
    tok_start = byte_pos;
    tok_len   = 16'd1;
    scan_mode = mode;
  endtask

  task automatic grow_token();
    if (tok_len != SAT16) tok_len++;
  endtask

  // A byte that fails to extend the pending token is scanned again from idle.
  task automatic lex_byte(input logic [7:0] c);
    logic  fresh;
    scan_e prev;
    fresh = 1'b1;
    prev = scan_mode;
    scan_mode = SC_IDLE;
    case (prev)
      SC_INT, SC_FRAC: begin
        if (is_digit(c)) begin
          grow_token();
          scan_mode = prev;
          fresh = 1'b0;
        end else if (prev == SC_INT && c == ".") begin
          grow_token();
          scan_mode = SC_FRAC;
          fresh = 1'b0;
        end else begin
          emit_token(K_NUMBER, E_NONE, tok_start, tok_len, 1'b0);
        end
      end
      SC_WORD: begin
        if (is_alpha(c) || is_digit(c)) begin
          if (tok_len < WORD_KEEP) word_chars[tok_len] = c;
          grow_token();
          scan_mode = SC_WORD;
          fresh = 1'b0;
        end else begin
          emit_token(word_kind(), E_NONE, tok_start, tok_len, 1'b0);
        end
      end
      SC_STR, SC_ESC: begin
        if (c == CH_NUL || c == CH_LF) begin
          emit_token(K_ERROR, E_UNTERM, tok_start, tok_len, 1'b0);
        end else begin
          grow_token();
          fresh = 1'b0;
          if (prev == SC_ESC) scan_mode = SC_STR;
          else if (c == "\\") scan_mode = SC_ESC;
          else if (c == "\"") emit_token(K_STRING, E_NONE, tok_start, tok_len, 1'b0);
          else scan_mode = SC_STR;
        end
      end
      SC_BANG: begin
        if (c == "=") begin
          emit_token(K_NE, E_NONE, tok_start, 16'd2, 1'b0);
          fresh = 1'b0;
        end else begin
          emit_token(K_ERROR, E_UNEXP, tok_start, 16'd1, 1'b0);
        end
      end
      SC_LT: begin
        fresh = 1'b0;
        if (c == "=") emit_token(K_LE, E_NONE, tok_start, 16'd2, 1'b0);
        else if (c == "-") emit_token(K_ARROW, E_NONE, tok_start, 16'd2, 1'b0);
        else begin
          emit_token(K_LT, E_NONE, tok_start, 16'd1, 1'b0);
          fresh = 1'b1;
        end
      end
      SC_GT: begin
        if (c == "=") begin
          emit_token(K_GE, E_NONE, tok_start, 16'd2, 1'b0);
          fresh = 1'b0;
        end else begin
          emit_token(K_GT, E_NONE, tok_start, 16'd1, 1'b0);
        end
      end
      default: ;
    endcase

    if (fresh) begin
      case (c)
        CH_NUL: emit_token(K_EOF, E_NONE, byte_pos, 16'd0, 1'b1);
        CH_LF: begin
          if (line_cnt != SAT16) line_cnt++;
        end
        " ", CH_TAB, CH_CR: ;
        "(": emit_token(K_LPAREN, E_NONE, byte_pos, 16'd1, 1'b0);
        ")": emit_token(K_RPAREN, E_NONE, byte_pos, 16'd1, 1'b0);
        "{": emit_token(K_LBRACE, E_NONE, byte_pos, 16'd1, 1'b0);
        "}": emit_token(K_RBRACE, E_NONE, byte_pos, 16'd1, 1'b0);
        "[": emit_token(K_LBRACKET, E_NONE, byte_pos, 16'd1, 1'b0);
        "]": emit_token(K_RBRACKET, E_NONE, byte_pos, 16'd1, 1'b0);
        ",": emit_token(K_COMMA, E_NONE, byte_pos, 16'd1, 1'b0);
        "=": emit_token(K_EQ, E_NONE, byte_pos, 16'd1, 1'b0);
        "+": emit_token(K_PLUS, E_NONE, byte_pos, 16'd1, 1'b0);
        "-": emit_token(K_MINUS, E_NONE, byte_pos, 16'd1, 1'b0);
        "*": emit_token(K_STAR, E_NONE, byte_pos, 16'd1, 1'b0);
        "/": emit_token(K_SLASH, E_NONE, byte_pos, 16'd1, 1'b0);
        "!": open_token(SC_BANG);
        "<": open_token(SC_LT);
        ">": open_token(SC_GT);
        "\"": open_token(SC_STR);
        default: begin
          if (is_digit(c)) begin
            open_token(SC_INT);
          end else if (is_alpha(c)) begin
            open_token(SC_WORD);
            word_chars[0] = c;
          end else begin
            emit_token(K_ERROR, E_UNEXP, byte_pos, 16'd1, 1'b0);
          end
        end
      endcase
    end

    // The end-of-source byte puts the whole scanner back to its reset state.
    if (c == CH_NUL) clear_scan();
    else if (byte_pos != SAT16) byte_pos++;
  endtask

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: token %0d field %s expected %0d got %0d",
               $time, checked_o, what, want, got);
      fail_cnt_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    plex_res_t want;
    if (!rst_ni) begin
      clear_scan();
      token_q.delete();
      fail_cnt_o = 0;
      checked_o = 0;
      pending_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) lex_byte(ch_i);
      if (out_valid_i && !out_stall_i) begin
        if (token_q.size() == 0) begin
          $display("%0t: expected no token, got kind %0d start %0d len %0d",
                   $time, kind_i, start_pos_i, tok_len_i);
          fail_cnt_o++;
        end else begin
          want = token_q.pop_front();
          check_field("kind", 16'(want.kind), 16'(kind_i));
          check_field("err_code", 16'(want.err_code), 16'(err_code_i));
          check_field("start_pos", want.start_pos, start_pos_i);
          check_field("tok_len", want.tok_len, tok_len_i);
          check_field("line_no", want.line_no, line_no_i);
          check_field("last", 16'(want.last), 16'(last_i));
          checked_o++;
        end
      end
      pending_o = token_q.size();
    end
  end

endmodule

### bench/tb_top.sv
// Top of the lexer testbench: clock, reset, source text stimulus and the verdict.
module tb_top;
  import plex_pkg::*;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam int ITEM_GOAL = 1950;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  ch_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [5:0]  kind_o;
  logic [1:0]  err_code_o;
  logic [15:0] start_pos_o;
  logic [15:0] tok_len_o;
  logic [15:0] line_no_o;
  logic        last_o;

  int fail_cnt;
  int pending;
  int checked;

  int tx_idle_pct;
  int rx_idle_pct;
  int items;
  int sources;

  logic [7:0] src_q [$];

  string word_set = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz_0123456789";
  string op_text [18] = '{
    "(", ")", "{", "}", "[", "]", ",", "=", "!=", "+", "-", "*", "/",
    "<", "<=", "<-", ">", ">="
  };

  pseudocode_lexer_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .ch_i        (ch_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .err_code_o  (err_code_o),
    .start_pos_o (start_pos_o),
    .tok_len_o   (tok_len_o),
    .line_no_o   (line_no_o),
    .last_o      (last_o)
  );

  plex_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .ch_i        (ch_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_i      (kind_o),
    .err_code_i  (err_code_o),
    .start_pos_i (start_pos_o),
    .tok_len_i   (tok_len_o),
    .line_no_i   (line_no_o),
    .last_i      (last_o),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < rx_idle_pct);
  end

  // Called just after a rising edge; returns just after the edge that took the byte.
  task automatic send_byte(input logic [7:0] b);
    if (items < ITEM_GOAL / 3) begin
      tx_idle_pct = 21;
      rx_idle_pct = 80;
    end else if (items < 2 * ITEM_GOAL / 3) begin
      tx_idle_pct = 80;
      rx_idle_pct = 21;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    ch_i <= b;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    items++;
  endtask

  task automatic send_source();
    foreach (src_q[i]) send_byte(src_q[i]);
    src_q.delete();
    sources++;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) src_q.push_back(s[i]);
  endtask

  task automatic add_blank();
    case ($urandom_range(0, 3))
      0: src_q.push_back(CH_TAB);
      1: src_q.push_back(CH_CR);
      2: src_q.push_back(CH_LF);
      default: src_q.push_back(" ");
    endcase
  endtask

  task automatic add_token();
    int         pick;
    int         k;
    int         twist;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      repeat ($urandom_range(1, 6)) src_q.push_back(8'("0" + $urandom_range(0, 9)));
      if ($urandom_range(0, 2) == 0) begin
        src_q.push_back(".");
        repeat ($urandom_range(0, 4)) src_q.push_back(8'("0" + $urandom_range(0, 9)));
      end
    end else if (pick < 35) begin
      // Keywords, sometimes bent into near misses of the table.
      k = $urandom_range(0, KW_COUNT - 1);
      twist = $urandom_range(0, 9);
      for (int j = 0; j < int'(KW_LEN[k]); j++) begin
        b = KW_TEXT[k][(int'(KW_LEN[k]) - 1 - j) * 8 +: 8];
        if (twist == 1 && j == 0) b = b | 8'h20;
        if (!(twist == 2 && j == int'(KW_LEN[k]) - 1)) src_q.push_back(b);
      end
      if (twist == 3) src_q.push_back(word_set[$urandom_range(0, 62)]);
    end else if (pick < 50) begin
      src_q.push_back(word_set[$urandom_range(0, 52)]);
      repeat ($urandom_range(0, 13)) src_q.push_back(word_set[$urandom_range(0, 62)]);
    end else if (pick < 62) begin
      src_q.push_back("\"");
      repeat ($urandom_range(0, 10)) begin
        if ($urandom_range(0, 4) == 0) begin
          src_q.push_back("\\");
          case ($urandom_range(0, 3))
            0: src_q.push_back("\"");
            1: src_q.push_back("\\");
            default: src_q.push_back(8'($urandom_range(32, 126)));
          endcase
        end else begin
          b = 8'($urandom_range(1, 255));
          if (b == CH_LF || b == "\"" || b == "\\") b = "a";
          src_q.push_back(b);
        end
      end
      case ($urandom_range(0, 19))
        0: src_q.push_back(CH_LF);
        1: begin
          src_q.push_back("\\");
          src_q.push_back(CH_LF);
        end
        2: begin
          src_q.push_back("\\");
          src_q.push_back(CH_NUL);
        end
        default: src_q.push_back("\"");
      endcase
    end else if (pick < 85) begin
      add_text(op_text[$urandom_range(0, 17)]);
    end else if (pick < 90) begin
      add_blank();
    end else if (pick < 98) begin
      case ($urandom_range(0, 3))
        0: src_q.push_back(".");
        1: src_q.push_back("\\");
        2: src_q.push_back("!");
        default: src_q.push_back(8'($urandom_range(1, 255)));
      endcase
    end else begin
      src_q.push_back(CH_NUL);
    end
    if ($urandom_range(0, 99) < 55) add_blank();
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    ch_i = '0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    items = 0;
    sources = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Every operator, a lone bang, a high byte, a number ending in a dot and a
    // string cut off by a line feed.
    add_text("(){}[],=+-*/<<=<->>=!!=");
    src_q.push_back(8'hFF);
    add_text("12.\"a");
    src_q.push_back(CH_LF);
    src_q.push_back(CH_NUL);
    send_source();

    while (items < ITEM_GOAL) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(5, 30)) src_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 20)) add_token();
      end
      if ($urandom_range(0, 9) != 0) src_q.push_back(CH_NUL);
      send_source();
    end

    in_valid_i <= 1'b0;
    for (int w = 0; w < 20000 && pending != 0; w++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (pending != 0) begin
      $display("%0t: expected %0d more tokens, got none", $time, pending);
    end
    $display("summary: %0d source bytes in %0d sources, %0d tokens checked",
             items, sources, checked);
    $display("summary: numbers, keywords and near misses, strings, errors and end of source");
    if (fail_cnt == 0 && pending == 0) begin
      $display("pseudocode_lexer_unit: match");
    end else begin
      $display("pseudocode_lexer_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("pseudocode_lexer_unit: mismatch");
    $finish;
  end

endmodule
